FILE: rtl/core/keyed_handler_hash_table_macros.svh
// Assertion macros shared by the checker files of the keyed handler map.
// Depends on nothing; each macro expects clock and reset in scope.
`ifndef KEYED_HANDLER_HASH_TABLE_MACROS_SVH
`define KEYED_HANDLER_HASH_TABLE_MACROS_SVH

// same-cycle implication
`define KHHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KHHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/khht_pkg.sv
// Shared types and constants for the keyed handler map.
// Used by the controller, datapath, remainder unit, top level and checker.
package khht_pkg;

   localparam int BUCKETS_DEF = 23;
   localparam int WAYS_DEF    = 4;
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int DIGIT_W     = 8;
   localparam int DIV_STEPS   = KEY_W / DIGIT_W;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_FLUSH  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_INVALID   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic div_step;
      logic mem_read;
      logic exec;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic div_last;
      logic rsp_busy;
   } sts_type;

endpackage

FILE: rtl/core/khht_mod.sv
// Bucket index unit: key mod BUCKETS, one 8-bit digit of the key per cycle while step is high.
// Depends on khht_pkg.
module khht_mod #(
   parameter int BUCKETS = khht_pkg::BUCKETS_DEF,
   localparam int RW = $clog2(BUCKETS) + 1,
   localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       step,
   input  logic [khht_pkg::KEY_W-1:0] key,
   output logic                       last,
   output logic [IW-1:0]              bucket
);

   localparam logic [RW-1:0] BMOD = RW'(BUCKETS);

   logic [khht_pkg::KEY_W-1:0]      sh_ff, sh_in;
   logic [RW-1:0]                   rem_ff, rem_in, rem_step;
   logic [khht_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;

   // restoring remainder over one digit; rem stays below BUCKETS
   always_comb begin
      logic [RW-1:0] r;
      logic [RW-1:0] t;
      r = rem_ff;
      for (int i = 0; i < khht_pkg::DIGIT_W; i++) begin
         t = RW'({r, sh_ff[khht_pkg::KEY_W-1-i]});
         if (t >= BMOD) begin
            t = t - BMOD;
         end
         r = t;
      end
      rem_step = r;
   end

   always_comb begin
      sh_in  = sh_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         sh_in  = key;
         rem_in = '0;
         cnt_in = '0;
      end else if (step) begin
         sh_in  = sh_ff << khht_pkg::DIGIT_W;
         rem_in = rem_step;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign last   = (cnt_ff == khht_pkg::STEP_CNT_W'(khht_pkg::DIV_STEPS - 1));
   assign bucket = rem_ff[IW-1:0];

endmodule

FILE: rtl/core/khht_dp.sv
// Datapath: operand registers, bucket index unit, key/value row memories,
// per-slot valid flops and the result register. Depends on khht_pkg, khht_mod.
module khht_dp #(
   parameter int BUCKETS = khht_pkg::BUCKETS_DEF,
   parameter int WAYS    = khht_pkg::WAYS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  khht_pkg::ctl_type          ctl,
   output khht_pkg::sts_type          sts,
   input  logic [1:0]                 req_cmd,
   input  logic [khht_pkg::KEY_W-1:0] req_key,
   input  logic [khht_pkg::VAL_W-1:0] req_value,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [khht_pkg::VAL_W-1:0] rsp_found_value
);

   localparam int IW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int KRW = WAYS * khht_pkg::KEY_W;
   localparam int VRW = WAYS * khht_pkg::VAL_W;

   khht_pkg::cmd_type          cmd_ff;
   logic [khht_pkg::KEY_W-1:0] key_ff;
   logic [khht_pkg::VAL_W-1:0] val_ff;

   logic          div_last;
   logic [IW-1:0] bucket;

   logic [KRW-1:0] key_mem_ff [BUCKETS];
   logic [VRW-1:0] val_mem_ff [BUCKETS];
   logic [KRW-1:0] krow_ff, krow_in;
   logic [VRW-1:0] vrow_ff, vrow_in;
   logic           row_we;

   logic [WAYS-1:0] valid_ff [BUCKETS];
   logic [WAYS-1:0] valid_in [BUCKETS];
   logic [WAYS-1:0] vbits;

   logic [WAYS-1:0] hit_vec;
   logic            hit_any, free_any;
   logic [WW-1:0]   hit_idx, free_idx;

   logic                       rsp_valid_ff, rsp_valid_in;
   khht_pkg::status_type       status_ff, status_in;
   logic [khht_pkg::VAL_W-1:0] found_ff, found_in;

   khht_mod #(.BUCKETS(BUCKETS)) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.capture),
      .step   (ctl.div_step),
      .key    (req_key),
      .last   (div_last),
      .bucket (bucket)
   );

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= khht_pkg::cmd_type'(req_cmd);
         key_ff <= req_key;
         val_ff <= req_value;
      end
   end

   // one row read per item, at most one row write-back
   always_ff @(posedge clock) begin
      if (ctl.mem_read) begin
         krow_ff <= key_mem_ff[bucket];
         vrow_ff <= val_mem_ff[bucket];
      end
      if (row_we) begin
         key_mem_ff[bucket] <= krow_in;
         val_mem_ff[bucket] <= vrow_in;
      end
   end

   assign vbits = valid_ff[bucket];

   // lowest way wins for both the match and the free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         hit_vec[w] = vbits[w] &&
                      (krow_ff[w*khht_pkg::KEY_W +: khht_pkg::KEY_W] == key_ff);
         if (hit_vec[w]) begin
            hit_idx = WW'(w);
         end
         if (!vbits[w]) begin
            free_idx = WW'(w);
         end
      end
      hit_any  = |hit_vec;
      free_any = ~&vbits;
   end

   always_comb begin
      valid_in     = valid_ff;
      krow_in      = krow_ff;
      vrow_in      = vrow_ff;
      row_we       = 1'b0;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      krow_in[free_idx*khht_pkg::KEY_W +: khht_pkg::KEY_W] = key_ff;
      vrow_in[free_idx*khht_pkg::VAL_W +: khht_pkg::VAL_W] = val_ff;
      if (ctl.exec) begin
         rsp_valid_in = 1'b1;
         found_in     = '0;
         status_in    = khht_pkg::ST_DONE;
         if (key_ff == '0) begin
            status_in = khht_pkg::ST_INVALID;
         end else begin
            unique case (cmd_ff)
               khht_pkg::CMD_LOOKUP: begin
                  if (hit_any) begin
                     found_in = vrow_ff[hit_idx*khht_pkg::VAL_W +: khht_pkg::VAL_W];
                  end else begin
                     status_in = khht_pkg::ST_NOT_FOUND;
                  end
               end
               khht_pkg::CMD_INSERT: begin
                  priority if (val_ff == '0) begin
                     status_in = khht_pkg::ST_INVALID;
                  end else if (hit_any) begin
                     status_in = khht_pkg::ST_DUPLICATE;
                  end else if (!free_any) begin
                     status_in = khht_pkg::ST_FULL;
                  end else begin
                     row_we                      = 1'b1;
                     valid_in[bucket][free_idx]  = 1'b1;
                  end
               end
               khht_pkg::CMD_REMOVE: begin
                  if (hit_any) begin
                     valid_in[bucket][hit_idx] = 1'b0;
                  end else begin
                     status_in = khht_pkg::ST_NOT_FOUND;
                  end
               end
               khht_pkg::CMD_FLUSH: begin
                  for (int b = 0; b < BUCKETS; b++) begin
                     valid_in[b] = '0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUCKETS; b++) begin
            valid_ff[b] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign sts.div_last    = div_last;
   assign sts.rsp_busy    = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;

endmodule

FILE: rtl/core/khht_ctrl.sv
// Controller: sequences capture, bucket index, row read and execute for one beat.
// Depends on khht_pkg.
module khht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  khht_pkg::sts_type sts,
   output khht_pkg::ctl_type ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_READ,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid)     state_in = S_DIVIDE;
         S_DIVIDE: if (sts.div_last)  state_in = S_READ;
         S_READ:                      state_in = S_EXEC;
         S_EXEC:   if (!sts.rsp_busy) state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign ctl.capture  = (state_ff == S_IDLE) && req_valid;
   assign ctl.div_step = (state_ff == S_DIVIDE);
   assign ctl.mem_read = (state_ff == S_READ);
   // hold the execute until the result register is free
   assign ctl.exec     = (state_ff == S_EXEC) && !sts.rsp_busy;

endmodule

FILE: rtl/core/keyed_handler_hash_table.sv
// Keyed handler map: WAYS slots per bucket, bucket = key mod BUCKETS.
// Sequence: a beat is taken only when idle; the bucket remainder follows
// (8 key bits a cycle), then one row read and one compare/write-back step,
// which waits while a previous response is still stalled.
// Reset: synchronous; all slot valid flops clear at once, no clearing pass.
// Flush with a nonzero key also clears all valid flops in its execute cycle.
module keyed_handler_hash_table #(
   parameter int BUCKETS = khht_pkg::BUCKETS_DEF,
   parameter int WAYS    = khht_pkg::WAYS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic [khht_pkg::KEY_W-1:0] req_key,
   input  logic [khht_pkg::VAL_W-1:0] req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_status,
   output logic [khht_pkg::VAL_W-1:0] rsp_found_value
);

   khht_pkg::ctl_type ctl;
   khht_pkg::sts_type sts;

   khht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   khht_dp #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule

FILE: rtl/core/khht_chk.sv
// Port-level checker for the keyed handler map, bound to the top level.
// Depends on khht_pkg and keyed_handler_hash_table_macros.svh.
`include "keyed_handler_hash_table_macros.svh"

module khht_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [2:0]                 rsp_status,
   input logic [khht_pkg::VAL_W-1:0] rsp_found_value
);

   `KHHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found_value), "rsp beat changed while stalled")

   `KHHT_ASSERT_NOW(a_status_range, rsp_valid, rsp_status <= khht_pkg::ST_FULL, "rsp_status out of range")

   `KHHT_ASSERT_NOW(a_found_zero, rsp_valid && rsp_status != khht_pkg::ST_DONE, rsp_found_value == '0, "found value set on a failed command")

   `KHHT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "second beat taken while busy")

endmodule

bind keyed_handler_hash_table khht_chk u_chk (.*);
